@@ rtl/mie_pkg.sv @@
// ----------------------------------------------------------------------------
// mie_pkg
// Shared types, widths and the control program of the modular inverse block.
// ----------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

	// operand width and derived widths
	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH);
	localparam int PC_W  = 4;

	typedef logic [WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [PC_W-1:0]  pc_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NOT_COPRIME = 2'd1,
		ST_MOD_ZERO    = 2'd2
	} status_t;

	// datapath operations of one control word
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_SETUP,
		OP_LTEST,
		OP_UPDATE,
		OP_FIN,
		OP_ZERO
	} op_t;

	// sequencing conditions
	typedef enum logic [2:0] {
		C_NEXT,
		C_JUMP,
		C_JUMP_R1Z,
		C_HOLD_DIV,
		C_HOLD_IN,
		C_HOLD_OUT
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	// program addresses
	localparam pc_t PC_IDLE   = PC_W'(0);
	localparam pc_t PC_CHKZ   = PC_W'(1);
	localparam pc_t PC_RED    = PC_W'(2);
	localparam pc_t PC_SETUP  = PC_W'(3);
	localparam pc_t PC_LTEST  = PC_W'(4);
	localparam pc_t PC_DIV    = PC_W'(5);
	localparam pc_t PC_UPDATE = PC_W'(6);
	localparam pc_t PC_FIN    = PC_W'(7);
	localparam pc_t PC_ZERO   = PC_W'(8);

	// control store
	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		w = '{op: OP_NONE, cond: C_JUMP, target: PC_IDLE};
		unique case (pc)
			PC_IDLE:   w = '{op: OP_LOAD,   cond: C_HOLD_IN,  target: PC_IDLE};
			PC_CHKZ:   w = '{op: OP_NONE,   cond: C_JUMP_R1Z, target: PC_ZERO};
			PC_RED:    w = '{op: OP_DIV,    cond: C_HOLD_DIV, target: PC_IDLE};
			PC_SETUP:  w = '{op: OP_SETUP,  cond: C_NEXT,     target: PC_IDLE};
			PC_LTEST:  w = '{op: OP_LTEST,  cond: C_JUMP_R1Z, target: PC_FIN};
			PC_DIV:    w = '{op: OP_DIV,    cond: C_HOLD_DIV, target: PC_IDLE};
			PC_UPDATE: w = '{op: OP_UPDATE, cond: C_JUMP,     target: PC_LTEST};
			PC_FIN:    w = '{op: OP_FIN,    cond: C_HOLD_OUT, target: PC_IDLE};
			PC_ZERO:   w = '{op: OP_ZERO,   cond: C_HOLD_OUT, target: PC_IDLE};
			default:   w = '{op: OP_NONE,   cond: C_JUMP,     target: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ rtl/mie_in_if.sv @@
// ----------------------------------------------------------------------------
// mie_in_if
// Request channel: value and modulus with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mie_in_if
	import mie_pkg::*;
	;
	logic  valid;
	logic  ready;
	word_t value;
	word_t modulus;

	modport source (output valid, output value, output modulus, input ready);
	modport sink (input valid, input value, input modulus, output ready);
endinterface

`default_nettype wire

@@ rtl/mie_out_if.sv @@
// ----------------------------------------------------------------------------
// mie_out_if
// Result channel: inverse, gcd and status with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mie_out_if
	import mie_pkg::*;
	;
	logic    valid;
	logic    ready;
	word_t   inverse;
	word_t   divisor;
	status_t status;

	modport source (output valid, output inverse, output divisor, output status,
		input ready);
	modport sink (input valid, input inverse, input divisor, input status,
		output ready);
endinterface

`default_nettype wire

@@ rtl/modular_inverse_ext_euclid.sv @@
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid
// Modular inverse and gcd by the extended Euclidean algorithm, run by a
// small microprogram over a bit-serial divide and multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel   | modport | payload                    | handshake
//  operand   | sink    | value, modulus             | valid / ready
//  result    | source  | inverse, divisor, status   | valid / ready
//
//  One request at a time. After acceptance the value is reduced by the
//  modulus, then each Euclid step runs a divide and a coefficient update;
//  the restoring divider retires one quotient bit per cycle. A zero modulus
//  goes from the zero check straight to the result. The result register
//  frees the sequencer: a new request is taken while a result still waits.
//  Reset clears the sequencer and the result valid flag; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse_ext_euclid
	import mie_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	mie_in_if.sink     operand,
	mie_out_if.source  result
);

	// control state
	pc_t    pc_q;
	logic   out_valid_q;

	// datapath registers
	word_t  r0_q, r1_q, m0_q, m1_q, n_q;
	word_t  dvd_q, rem_q, prod_q;
	cnt_t   cnt_q;
	logic   neg_q, par_q;
	word_t  inverse_q, divisor_q;
	status_t status_q;

	uword_t uw;
	pc_t    pc_d;
	logic   in_fire, out_free, r1_zero, div_last;

	logic [WIDTH:0] shl, diff;
	logic   qbit;
	word_t  rem_next, prod_next, mm, inv_raw;

	// control word decode
	assign uw       = ucode(pc_q);
	assign in_fire  = operand.valid && operand.ready;
	assign out_free = !out_valid_q || result.ready;
	assign r1_zero  = (r1_q == '0);
	assign div_last = (cnt_q == CNT_W'(WIDTH - 1));

	assign operand.ready  = (uw.op == OP_LOAD);
	assign result.valid   = out_valid_q;
	assign result.inverse = inverse_q;
	assign result.divisor = divisor_q;
	assign result.status  = status_q;

	// restoring divide step with horner accumulation of quotient times m1
	always_comb begin
		shl       = {rem_q, dvd_q[WIDTH-1]};
		diff      = shl - {1'b0, r1_q};
		qbit      = ~diff[WIDTH];
		rem_next  = qbit ? diff[WIDTH-1:0] : shl[WIDTH-1:0];
		prod_next = {prod_q[WIDTH-2:0], 1'b0} + (qbit ? m1_q : '0);
	end

	// normalize the final coefficient into 0..n-1
	always_comb begin
		mm      = (m0_q == n_q) ? '0 : m0_q;
		inv_raw = (neg_q && (m0_q != '0)) ? (n_q - mm) : mm;
	end

	// next program address
	always_comb begin
		pc_d = pc_q + 1'b1;
		case (uw.cond)
			C_NEXT:     pc_d = pc_q + 1'b1;
			C_JUMP:     pc_d = uw.target;
			C_JUMP_R1Z: pc_d = r1_zero ? uw.target : pc_q + 1'b1;
			C_HOLD_DIV: pc_d = div_last ? pc_q + 1'b1 : pc_q;
			C_HOLD_IN:  pc_d = in_fire ? pc_q + 1'b1 : pc_q;
			C_HOLD_OUT: pc_d = out_free ? uw.target : pc_q;
			default:    pc_d = PC_IDLE;
		endcase
	end

	// sequencer and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if ((uw.op == OP_FIN || uw.op == OP_ZERO) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath driven by the control word
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_LOAD: begin
				if (in_fire) begin
					dvd_q  <= operand.value;
					r1_q   <= operand.modulus;
					n_q    <= operand.modulus;
					rem_q  <= '0;
					prod_q <= '0;
					cnt_q  <= '0;
					m1_q   <= '0;
				end
			end
			OP_DIV: begin
				rem_q  <= rem_next;
				prod_q <= prod_next;
				dvd_q  <= {dvd_q[WIDTH-2:0], 1'b0};
				cnt_q  <= cnt_q + 1'b1;
			end
			OP_SETUP: begin
				r0_q  <= r1_q;
				r1_q  <= rem_q;
				m0_q  <= '0;
				m1_q  <= WIDTH'(1);
				neg_q <= 1'b0;
				par_q <= 1'b0;
			end
			OP_LTEST: begin
				dvd_q  <= r0_q;
				rem_q  <= '0;
				prod_q <= '0;
				cnt_q  <= '0;
			end
			OP_UPDATE: begin
				r0_q  <= r1_q;
				r1_q  <= rem_q;
				m0_q  <= m1_q;
				m1_q  <= m0_q + prod_q;
				neg_q <= par_q;
				par_q <= ~par_q;
			end
			OP_FIN: begin
				if (out_free) begin
					divisor_q <= r0_q;
					if (r0_q == WIDTH'(1)) begin
						inverse_q <= inv_raw;
						status_q  <= ST_OK;
					end else begin
						inverse_q <= '0;
						status_q  <= ST_NOT_COPRIME;
					end
				end
			end
			OP_ZERO: begin
				if (out_free) begin
					divisor_q <= dvd_q;
					inverse_q <= '0;
					status_q  <= ST_MOD_ZERO;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the modular inverse block. Requests are value/modulus pairs. A
// predictor runs the extended Euclidean algorithm at the block's width. Each
// returned inverse, gcd and status is compared with the oldest prediction.
// Both channels idle at random, the receiver once stalls for a long stretch,
// and the sender once waits for the block to drain.
// ----------------------------------------------------------------------------

module testbench;
	import mie_pkg::*;

	localparam int STEP_LIMIT       = 128;
	localparam int MAX_GAP          = 19;
	localparam int RANDOM_REQUESTS  = 400;
	localparam int DRAIN_AT         = 250;
	localparam int LONG_HOLD_AT     = 120;
	localparam int LONG_HOLD_CYCLES = 3000;
	localparam int SETTLE_CYCLES    = 2000;

	typedef struct {
		word_t value;
		word_t modulus;
		bit    drain;
	} request_t;

	typedef struct {
		word_t   inverse;
		word_t   divisor;
		status_t status;
	} answer_t;

	logic clk;
	logic arst_n;

	mie_in_if  operand_if ();
	mie_out_if result_if ();

	modular_inverse_ext_euclid u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand_if),
		.result  (result_if)
	);

	request_t pending_requests[$];
	answer_t  expected_answers[$];

	int  n_accepted;
	int  n_checked;
	int  n_errors = 0;
	int  send_wait;
	int  recv_stall;
	int  recv_draw;
	bit  long_hold_done;
	bit  accept_now;
	int  n_ok = 0;
	int  n_not_coprime = 0;
	int  n_mod_zero = 0;
	answer_t got;
	answer_t want;

	// extended euclid on (modulus, value mod modulus), magnitudes plus sign
	function automatic answer_t solve_inverse(input word_t a, input word_t n);
		answer_t ans;
		word_t   r0, r1, r2, q, m0, m1, m2;
		bit      neg;
		int      k;
		if (n == '0) begin
			ans.inverse = '0;
			ans.divisor = a;
			ans.status  = ST_MOD_ZERO;
			return ans;
		end
		r0  = n;
		r1  = a % n;
		m0  = '0;
		m1  = word_t'(1);
		neg = 1'b0;
		for (k = 0; k < STEP_LIMIT && r1 != '0; k++) begin
			q   = r0 / r1;
			r2  = r0 - q * r1;
			m2  = m0 + q * m1;
			r0  = r1;
			r1  = r2;
			m0  = m1;
			m1  = m2;
			neg = k[0];
		end
		ans.divisor = r0;
		if (r0 == word_t'(1)) begin
			ans.status  = ST_OK;
			ans.inverse = (neg && m0 != '0) ? n - (m0 % n) : m0 % n;
		end else begin
			ans.status  = ST_NOT_COPRIME;
			ans.inverse = '0;
		end
		return ans;
	endfunction

	task automatic add_request(input word_t value, input word_t modulus, input bit drain);
		request_t req;
		req.value   = value;
		req.modulus = modulus;
		req.drain   = drain;
		pending_requests.insert(pending_requests.size(), req);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// request driver: holds a request until taken, then idles a drawn gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operand_if.valid   <= 1'b0;
			operand_if.value   <= '0;
			operand_if.modulus <= '0;
			send_wait          <= 0;
			n_accepted         <= 0;
		end else begin
			accept_now = operand_if.valid && operand_if.ready;
			if (accept_now) begin
				expected_answers.insert(expected_answers.size(),
					solve_inverse(operand_if.value, operand_if.modulus));
				n_accepted <= n_accepted + 1;
			end
			if (operand_if.valid && !operand_if.ready) begin
				// keep offering the same request
			end else if (send_wait > 0) begin
				operand_if.valid <= 1'b0;
				send_wait        <= send_wait - 1;
			end else if (pending_requests.size() > 0 && !(pending_requests[0].drain &&
					n_accepted + int'(accept_now) != n_checked)) begin
				operand_if.value   <= pending_requests[0].value;
				operand_if.modulus <= pending_requests[0].modulus;
				operand_if.valid   <= 1'b1;
				void'(pending_requests.pop_front());
				send_wait <= (((n_accepted / 50) % 3) == 1) ? 0 : $urandom_range(0, MAX_GAP);
			end else begin
				operand_if.valid <= 1'b0;
			end
		end
	end

	// result monitor: compare with the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			recv_stall      <= 0;
			long_hold_done  <= 1'b0;
			n_checked       <= 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				got.inverse = result_if.inverse;
				got.divisor = result_if.divisor;
				got.status  = result_if.status;
				if (expected_answers.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected result inverse=%h divisor=%h status=%0d",
						$time, got.inverse, got.divisor, got.status);
				end else begin
					want = expected_answers.pop_front();
					if (got.inverse !== want.inverse || got.divisor !== want.divisor ||
							got.status !== want.status) begin
						n_errors++;
						$display("%0t: mismatch expected inv=%h gcd=%h st=%0d, got inv=%h gcd=%h st=%0d",
							$time, want.inverse, want.divisor, want.status,
							got.inverse, got.divisor, got.status);
					end
					case (want.status)
						ST_OK:          n_ok++;
						ST_NOT_COPRIME: n_not_coprime++;
						ST_MOD_ZERO:    n_mod_zero++;
						default:        ;
					endcase
				end
				n_checked <= n_checked + 1;
			end
			if (!long_hold_done && n_checked == LONG_HOLD_AT) begin
				// one long hold-off so the block backs up into the request side
				long_hold_done  <= 1'b1;
				recv_stall      <= LONG_HOLD_CYCLES;
				result_if.ready <= 1'b0;
			end else if (result_if.valid && result_if.ready) begin
				recv_draw = (((n_checked / 40) % 3) == 2) ? 0 : $urandom_range(0, MAX_GAP);
				result_if.ready <= (recv_draw == 0);
				recv_stall      <= (recv_draw == 0) ? 0 : recv_draw - 1;
			end else if (recv_stall > 0) begin
				result_if.ready <= 1'b0;
				recv_stall      <= recv_stall - 1;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// reset, stimulus and end of run
	initial begin
		int    i;
		int    kind;
		word_t g;
		word_t x;
		word_t y;
		word_t v;
		word_t n;
		bit    missing;

		arst_n  = 1'b0;
		missing = 1'b0;

		// directed: zero and one moduli, zero value, reduction, extremes
		add_request('0, '0, 1'b0);
		add_request('1, '0, 1'b0);
		add_request(32'd12345, '0, 1'b0);
		add_request('0, 32'd1, 1'b0);
		add_request(32'd5, 32'd1, 1'b0);
		add_request('1, 32'd1, 1'b0);
		add_request('0, 32'd7, 1'b0);
		add_request('0, '1, 1'b0);
		add_request(32'd3, 32'd7, 1'b0);
		add_request(32'd10, 32'd7, 1'b0);
		add_request(32'd7, 32'd7, 1'b0);
		add_request(32'd6, 32'd9, 1'b0);
		add_request(32'd12, 32'd18, 1'b0);
		add_request('1, '1, 1'b0);
		add_request(32'hFFFF_FFFE, '1, 1'b0);
		add_request(32'd1, '1, 1'b0);
		add_request(32'd2, '1, 1'b0);
		add_request('1, 32'd2, 1'b0);
		add_request(32'd1836311903, 32'd2971215073, 1'b0);
		add_request(32'd2971215073, 32'd1836311903, 1'b0);
		add_request(32'h8000_0000, 32'hFFFF_FFFB, 1'b0);
		add_request(32'd65537, 32'hFFFF_FFFB, 1'b0);
		add_request(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
		add_request(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);

		// random mix of operand shapes
		for (i = 0; i < RANDOM_REQUESTS; i++) begin
			kind = $urandom_range(0, 9);
			case (kind)
				5: begin
					v = $urandom;
					n = $urandom_range(1, 255);
				end
				6: begin
					g = $urandom_range(2, 65535);
					x = $urandom_range(0, 65535);
					y = $urandom_range(1, 65535);
					v = g * x;
					n = g * y;
				end
				7: begin
					v = ($urandom_range(0, 2) == 0) ? '0 : word_t'($urandom);
					case ($urandom_range(0, 2))
						0:       n = '0;
						1:       n = word_t'(1);
						default: n = $urandom;
					endcase
				end
				8: begin
					n = $urandom >> $urandom_range(8, 31);
					v = $urandom;
				end
				9: begin
					v = $urandom >> $urandom_range(0, 31);
					n = $urandom >> $urandom_range(0, 31);
				end
				default: begin
					v = $urandom;
					n = $urandom;
				end
			endcase
			add_request(v, n, i == DRAIN_AT);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// wait until every request is taken and answered
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || operand_if.valid || n_accepted != n_checked);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (expected_answers.size() != 0) begin
			missing = 1'b1;
			$display("%0t: %0d expected results never arrived", $time,
				expected_answers.size());
		end
		$display("run covered %0d requests: %0d inverses, %0d not coprime, %0d zero moduli",
			n_checked, n_ok, n_not_coprime, n_mod_zero);
		$display("included a %0d-cycle result hold-off and one full drain before a request",
			LONG_HOLD_CYCLES);
		if (n_errors == 0 && !missing) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
